[rtl/qrs_pkg.sv]
package qrs_pkg;

    // Field widths of the item payloads
    localparam int COEF_W    = 32;
    localparam int ROOT_W    = 32;
    localparam int FRAC_BITS = 16;

    localparam logic [ROOT_W-1:0] ROOT_POS_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic [ROOT_W-1:0] ROOT_NEG_MAX = {1'b1, {(ROOT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_REAL_PAIR   = 2'd0,
        KIND_REAL_REPEAT = 2'd1,
        KIND_COMPLEX     = 2'd2,
        KIND_DEGENERATE  = 2'd3
    } t_root_kind;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_coef;

    typedef struct packed {
        logic signed [ROOT_W-1:0] root1_real;
        logic signed [ROOT_W-1:0] root1_imag;
        logic signed [ROOT_W-1:0] root2_real;
        logic signed [ROOT_W-1:0] root2_imag;
        logic [1:0]               root_kind;
        logic                     overflow;
    } t_roots;

endpackage

[rtl/quadratic_root_solver.sv]
// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     i_in_data   (qrs_pkg::t_coef)
// out      output     o_out_valid / i_out_ready   o_out_data  (qrs_pkg::t_roots)
//
// One item enters per cycle unless the output stalls. The pipeline length is set by
// the bit-serial square root (one root bit per stage) and the restoring divider (one
// quotient bit per stage).
// Reset clears only the valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline in place, so o_in_ready drops while a
// finished item waits and nothing is lost or repeated.
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  qrs_pkg::t_coef  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output qrs_pkg::t_roots o_out_data
);

    localparam int W    = qrs_pkg::COEF_W;
    localparam int RW   = qrs_pkg::ROOT_W;
    localparam int PW   = 2*W;            // coefficient products
    localparam int DMW  = 2*W + 2;        // discriminant magnitude, padded even
    localparam int SRW  = W + 1;          // square root of the discriminant
    localparam int NSW  = W + 3;          // signed numerator -b +/- sqrt
    localparam int NMW  = W + 2;          // numerator magnitude
    localparam int NNW  = W + FRAC_BITS + 3; // scaled, rounding-biased numerator
    localparam int DENW = W + 1;          // divisor 2|a|
    localparam int LAT  = 6 + SRW + NNW;

    typedef struct packed {
        logic              aneg;
        logic [W-1:0]      am;
        logic signed [W:0] nb;     // -b
        logic              dneg;
        logic              azero;
    } t_sb_sq;

    typedef struct packed {
        logic                neg1;
        logic                neg2;
        logic                negi1;
        logic                negi2;
        qrs_pkg::t_root_kind kind;
    } t_sb_div;

    logic w_en;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    // Whole pipeline advances unless a finished item is waiting on the output
    assign w_en        = ~r_vld[LAT-1] | i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_comb begin
        n_vld = {r_vld[LAT-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // Stage 1: capture the item
    qrs_pkg::t_coef r_s1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= i_in_data;
        end
    end

    // Stage 2: magnitudes and the two products
    logic [W-1:0]  a_u, b_u, c_u;
    logic          n_s2_aneg, n_s2_bneg, n_s2_sdiff;
    logic [W-1:0]  n_s2_am, n_s2_bm, n_s2_cm;
    logic [PW-1:0] n_s2_bsq, n_s2_ac;
    logic          r_s2_aneg, r_s2_bneg, r_s2_sdiff;
    logic [W-1:0]  r_s2_am, r_s2_bm;
    logic [PW-1:0] r_s2_bsq, r_s2_ac;

    assign a_u = r_s1.coef_a;
    assign b_u = r_s1.coef_b;
    assign c_u = r_s1.coef_c;

    always_comb begin
        n_s2_aneg  = a_u[W-1];
        n_s2_bneg  = b_u[W-1];
        n_s2_sdiff = a_u[W-1] ^ c_u[W-1];
        n_s2_am    = a_u[W-1] ? (~a_u + 1'b1) : a_u;
        n_s2_bm    = b_u[W-1] ? (~b_u + 1'b1) : b_u;
        n_s2_cm    = c_u[W-1] ? (~c_u + 1'b1) : c_u;
        n_s2_bsq   = PW'(n_s2_bm) * PW'(n_s2_bm);
        n_s2_ac    = PW'(n_s2_am) * PW'(n_s2_cm);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_aneg  <= n_s2_aneg;
            r_s2_bneg  <= n_s2_bneg;
            r_s2_sdiff <= n_s2_sdiff;
            r_s2_am    <= n_s2_am;
            r_s2_bm    <= n_s2_bm;
            r_s2_bsq   <= n_s2_bsq;
            r_s2_ac    <= n_s2_ac;
        end
    end

    // Stage 3: discriminant magnitude and sign, exact
    logic [DMW-1:0] bsq_x, p_x;
    logic [DMW-1:0] n_s3_dmag;
    t_sb_sq         n_s3_sb;
    logic [DMW-1:0] r_s3_dmag;
    t_sb_sq         r_s3_sb;

    always_comb begin
        bsq_x            = DMW'(r_s2_bsq);
        p_x              = {r_s2_ac, 2'b00};
        n_s3_sb.aneg     = r_s2_aneg;
        n_s3_sb.am       = r_s2_am;
        n_s3_sb.azero    = (r_s2_am == '0);
        n_s3_sb.nb       = r_s2_bneg ? $signed({1'b0, r_s2_bm}) : -$signed({1'b0, r_s2_bm});
        if (r_s2_sdiff) begin
            n_s3_dmag    = bsq_x + p_x;
            n_s3_sb.dneg = 1'b0;
        end else if (bsq_x >= p_x) begin
            n_s3_dmag    = bsq_x - p_x;
            n_s3_sb.dneg = 1'b0;
        end else begin
            n_s3_dmag    = p_x - bsq_x;
            n_s3_sb.dneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_dmag <= n_s3_dmag;
            r_s3_sb   <= n_s3_sb;
        end
    end

    // Square root, carrying the item's sideband along
    logic [SRW-1:0] sq_root;
    t_sb_sq         sq_sb;

    qrs_sqrt #(
        .RW  (SRW),
        .SBW ($bits(t_sb_sq))
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_s3_dmag),
        .i_sb   (r_s3_sb),
        .o_root (sq_root),
        .o_sb   (sq_sb)
    );

    // Stage 4: classify and form the signed numerators
    logic signed [NSW-1:0] sx, nbx;
    logic signed [NSW-1:0] n_s4_sr1, n_s4_sr2;
    qrs_pkg::t_root_kind   n_s4_kind;
    logic signed [NSW-1:0] r_s4_sr1, r_s4_sr2;
    logic [SRW-1:0]        r_s4_s;
    qrs_pkg::t_root_kind   r_s4_kind;
    logic                  r_s4_aneg;
    logic [W-1:0]          r_s4_am;

    always_comb begin
        sx  = $signed({{(NSW-SRW){1'b0}}, sq_root});
        nbx = NSW'(sq_sb.nb);
        if (sq_sb.azero) begin
            n_s4_kind = qrs_pkg::KIND_DEGENERATE;
        end else if (sq_root == '0) begin
            n_s4_kind = qrs_pkg::KIND_REAL_REPEAT;
        end else if (sq_sb.dneg) begin
            n_s4_kind = qrs_pkg::KIND_COMPLEX;
        end else begin
            n_s4_kind = qrs_pkg::KIND_REAL_PAIR;
        end
        // Complex pair: both real parts come from -b alone
        n_s4_sr1 = sq_sb.dneg ? nbx : nbx + sx;
        n_s4_sr2 = sq_sb.dneg ? nbx : nbx - sx;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_sr1  <= n_s4_sr1;
            r_s4_sr2  <= n_s4_sr2;
            r_s4_s    <= sq_root;
            r_s4_kind <= n_s4_kind;
            r_s4_aneg <= sq_sb.aneg;
            r_s4_am   <= sq_sb.am;
        end
    end

    // Stage 5: magnitudes, scale by 2^FRAC_BITS, add |a| so the floor rounds half away
    logic [NSW-1:0]           m1, m2;
    logic [2:0][NNW-1:0]      n_s5_num;
    logic [DENW-1:0]          n_s5_den;
    t_sb_div                  n_s5_sb;
    logic [2:0][NNW-1:0]      r_s5_num;
    logic [DENW-1:0]          r_s5_den;
    t_sb_div                  r_s5_sb;

    always_comb begin
        m1 = r_s4_sr1[NSW-1] ? NSW'(-r_s4_sr1) : NSW'(r_s4_sr1);
        m2 = r_s4_sr2[NSW-1] ? NSW'(-r_s4_sr2) : NSW'(r_s4_sr2);
        n_s5_num[0]   = (NNW'(m1[NMW-1:0]) << FRAC_BITS) + NNW'(r_s4_am);
        n_s5_num[1]   = (NNW'(m2[NMW-1:0]) << FRAC_BITS) + NNW'(r_s4_am);
        n_s5_num[2]   = (NNW'(r_s4_s) << FRAC_BITS) + NNW'(r_s4_am);
        n_s5_den      = {r_s4_am, 1'b0};
        n_s5_sb.neg1  = r_s4_sr1[NSW-1] ^ r_s4_aneg;
        n_s5_sb.neg2  = r_s4_sr2[NSW-1] ^ r_s4_aneg;
        n_s5_sb.negi1 = r_s4_aneg;
        n_s5_sb.negi2 = ~r_s4_aneg;
        n_s5_sb.kind  = r_s4_kind;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_num <= n_s5_num;
            r_s5_den <= n_s5_den;
            r_s5_sb  <= n_s5_sb;
        end
    end

    // Three quotient lanes: first root, second root, imaginary magnitude
    logic [2:0][NNW-1:0] dv_quo;
    t_sb_div             dv_sb;

    qrs_div #(
        .NW    (NNW),
        .DW    (DENW),
        .LANES (3),
        .SBW   ($bits(t_sb_div))
    ) u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s5_num),
        .i_den (r_s5_den),
        .i_sb  (r_s5_sb),
        .o_quo (dv_quo),
        .o_sb  (dv_sb)
    );

    // Stage 6: apply sign, saturate, select fields by kind
    function automatic logic [RW:0] f_sat(input logic [NNW-1:0] q, input logic neg);
        logic [RW:0] res;
        if (neg) begin
            if (q > NNW'(qrs_pkg::ROOT_NEG_MAX)) begin
                res = {1'b1, qrs_pkg::ROOT_NEG_MAX};
            end else begin
                res = {1'b0, RW'(NNW'(0) - q)};
            end
        end else begin
            if (q > NNW'(qrs_pkg::ROOT_POS_MAX)) begin
                res = {1'b1, qrs_pkg::ROOT_POS_MAX};
            end else begin
                res = {1'b0, RW'(q)};
            end
        end
        return res;
    endfunction

    logic [RW:0]     sat1, sat2, sati1, sati2;
    qrs_pkg::t_roots n_out;
    qrs_pkg::t_roots r_out;

    always_comb begin
        sat1  = f_sat(dv_quo[0], dv_sb.neg1);
        sat2  = f_sat(dv_quo[1], dv_sb.neg2);
        sati1 = f_sat(dv_quo[2], dv_sb.negi1);
        sati2 = f_sat(dv_quo[2], dv_sb.negi2);
        n_out = '0;
        n_out.root_kind = dv_sb.kind;
        case (dv_sb.kind)
            qrs_pkg::KIND_REAL_PAIR, qrs_pkg::KIND_REAL_REPEAT: begin
                n_out.root1_real = sat1[RW-1:0];
                n_out.root2_real = sat2[RW-1:0];
                n_out.overflow   = sat1[RW] | sat2[RW];
            end
            qrs_pkg::KIND_COMPLEX: begin
                n_out.root1_real = sat1[RW-1:0];
                n_out.root2_real = sat1[RW-1:0];
                n_out.root1_imag = sati1[RW-1:0];
                n_out.root2_imag = sati2[RW-1:0];
                n_out.overflow   = sat1[RW] | sati1[RW] | sati2[RW];
            end
            default: begin
                // a is zero: all roots stay zero, no overflow
                n_out.overflow = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/qrs_sqrt.sv]
// Integer square root, one result bit per stage.
module qrs_sqrt #(
    parameter int RW  = 33,
    parameter int SBW = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SBW-1:0]  i_sb,
    output logic [RW-1:0]   o_root,
    output logic [SBW-1:0]  o_sb
);

    logic [2*RW-1:0] r_rad  [RW-1];
    logic [RW+1:0]   r_rem  [RW-1];
    logic [RW-1:0]   r_root [RW];
    logic [SBW-1:0]  r_sb   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [2*RW-1:0] rad_in;
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [SBW-1:0]  sb_in;
        logic [RW+3:0]   rem_t;
        logic [RW+3:0]   trial;
        logic            ge;
        logic [2*RW-1:0] n_rad;
        logic [RW+1:0]   n_rem;
        logic [RW-1:0]   n_root;

        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = i_sb;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign sb_in   = r_sb[k-1];
        end

        always_comb begin
            rem_t  = {rem_in, rad_in[2*RW-1 -: 2]};
            trial  = {2'b00, root_in, 2'b01};
            ge     = (rem_t >= trial);
            n_rem  = ge ? (RW+2)'(rem_t - trial) : (RW+2)'(rem_t);
            n_root = {root_in[RW-2:0], ge};
            n_rad  = {rad_in[2*RW-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
                r_sb[k]   <= sb_in;
            end
        end

        // Drop the partial remainder after the last stage
        if (k < RW-1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k] <= n_rad;
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_root = r_root[RW-1];
    assign o_sb   = r_sb[RW-1];

endmodule

[rtl/qrs_div.sv]
// Restoring divider, one quotient bit per stage, several lanes on a shared divisor.
module qrs_div #(
    parameter int NW    = 51,
    parameter int DW    = 33,
    parameter int LANES = 3,
    parameter int SBW   = 1
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [LANES-1:0][NW-1:0]  i_num,
    input  logic [DW-1:0]             i_den,
    input  logic [SBW-1:0]            i_sb,
    output logic [LANES-1:0][NW-1:0]  o_quo,
    output logic [SBW-1:0]            o_sb
);

    logic [LANES-1:0][NW-1:0] r_num [NW];
    logic [LANES-1:0][DW-1:0] r_rem [NW-1];
    logic [DW-1:0]            r_den [NW-1];
    logic [SBW-1:0]           r_sb  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [LANES-1:0][NW-1:0] num_in;
        logic [LANES-1:0][DW-1:0] rem_in;
        logic [DW-1:0]            den_in;
        logic [SBW-1:0]           sb_in;
        logic [LANES-1:0][DW:0]   t;
        logic [LANES-1:0]         ge;
        logic [LANES-1:0][NW-1:0] n_num;
        logic [LANES-1:0][DW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign num_in = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign num_in = r_num[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign sb_in  = r_sb[k-1];
        end

        // Quotient bits shift in where numerator bits leave
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                t[l]     = {rem_in[l], num_in[l][NW-1]};
                ge[l]    = (t[l] >= {1'b0, den_in});
                n_rem[l] = ge[l] ? DW'(t[l] - {1'b0, den_in}) : DW'(t[l]);
                n_num[l] = {num_in[l][NW-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= n_num;
                r_sb[k]  <= sb_in;
            end
        end

        if (k < NW-1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_num[NW-1];
    assign o_sb  = r_sb[NW-1];

endmodule

[rtl/qrs_checker.sv]
module qrs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input qrs_pkg::t_roots o_out_data
);

    // Hold a waiting item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && i_rst_n |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && i_rst_n |=> $stable(o_out_data))
        else $error("output item changed while stalled");

    // Input side only stalls behind a waiting output item
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.root_kind == qrs_pkg::KIND_DEGENERATE |->
        o_out_data.root1_real == '0 && o_out_data.root2_real == '0 &&
        o_out_data.root1_imag == '0 && o_out_data.root2_imag == '0 &&
        !o_out_data.overflow)
        else $error("degenerate item carries nonzero roots");

    a_real_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.root_kind == qrs_pkg::KIND_REAL_PAIR ||
        o_out_data.root_kind == qrs_pkg::KIND_REAL_REPEAT) |->
        o_out_data.root1_imag == '0 && o_out_data.root2_imag == '0)
        else $error("real roots with nonzero imaginary part");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
